### hdl/sscp_pkg.sv
// sscp_pkg: shared constants, types and helpers for the saturating-sum char predictor
// depends on nothing; used by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package sscp_pkg;

	localparam int DIM        = 32;
	localparam int VOCAB_MAX  = 64;
	localparam int DIM_W      = $clog2(DIM);
	localparam int VOCAB_W    = $clog2(VOCAB_MAX);
	localparam int ADDR_W     = VOCAB_W + DIM_W;
	localparam int TABLE_DEPTH = VOCAB_MAX * DIM;
	localparam int EMB_W      = 4;
	localparam int WEIGHT_W   = 16;
	localparam int PROD_W     = WEIGHT_W + EMB_W;
	localparam int SCORE_W    = 25;
	localparam int CFG_W      = 7;
	localparam int MODE_W     = 3;

	localparam logic [CFG_W-1:0] VOCAB_RESET = CFG_W'(39);
	localparam logic signed [EMB_W:0] EMB_HI = (EMB_W+1)'(4);
	localparam logic signed [EMB_W:0] EMB_LO = -(EMB_W+1)'(4);

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD_EMB = 3'd0,
		MODE_LOAD_H   = 3'd1,
		MODE_LOAD_S   = 3'd2,
		MODE_LOAD_B   = 3'd3,
		MODE_CLEAR    = 3'd4,
		MODE_STEP     = 3'd5
	} mode_t;

	// tag that travels with each multiply-accumulate beat
	typedef struct packed {
		logic               valid;
		logic               first;
		logic               last;
		logic               fin;
		logic [VOCAB_W-1:0] v;
	} tag_t;

	typedef struct packed {
		logic                      fire;
		logic [VOCAB_W-1:0]        id;
		logic signed [SCORE_W-1:0] score;
	} result_t;

	// clamp a widened embedding sum to -4..4
	function automatic logic signed [EMB_W-1:0] clamp_emb(input logic signed [EMB_W:0] x);
		logic signed [EMB_W:0] r;
		r = x;
		if (x > EMB_HI) r = EMB_HI;
		if (x < EMB_LO) r = EMB_LO;
		return r[EMB_W-1:0];
	endfunction

endpackage

`default_nettype wire

### hdl/sscp_mac.sv
// sscp_mac: shared multiply pair, row accumulator and running argmax
// depends on sscp_pkg
`timescale 1ns / 1ps
`default_nettype none

module sscp_mac (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sscp_pkg::tag_t                         tag_s1,
	input  logic signed [sscp_pkg::WEIGHT_W-1:0]   head_h_s1,
	input  logic signed [sscp_pkg::WEIGHT_W-1:0]   head_s_s1,
	input  logic signed [sscp_pkg::WEIGHT_W-1:0]   bias_s1,
	input  logic signed [sscp_pkg::EMB_W-1:0]      emb_s1,
	input  logic signed [sscp_pkg::EMB_W-1:0]      sum_s1,
	output sscp_pkg::result_t                      res
);

	sscp_pkg::tag_t                           tag_s2;
	logic signed [sscp_pkg::PROD_W-1:0]       ph_s2;
	logic signed [sscp_pkg::PROD_W-1:0]       ps_s2;
	logic signed [sscp_pkg::WEIGHT_W-1:0]     bias_s2;
	logic signed [sscp_pkg::SCORE_W-1:0]      acc_q;
	logic signed [sscp_pkg::SCORE_W-1:0]      lead_score_q;
	logic [sscp_pkg::VOCAB_W-1:0]             best_id_q;
	logic signed [sscp_pkg::SCORE_W-1:0]      acc_base;
	logic signed [sscp_pkg::SCORE_W-1:0]      acc_next;
	logic                                     take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		ph_s2   <= sscp_pkg::PROD_W'(head_h_s1) * sscp_pkg::PROD_W'(emb_s1);
		ps_s2   <= sscp_pkg::PROD_W'(head_s_s1) * sscp_pkg::PROD_W'(sum_s1);
		bias_s2 <= bias_s1;
	end

	// a row score never exceeds about 2^23 in magnitude, so 25 bits never overflow
	always_comb begin
		acc_base = tag_s2.first ? sscp_pkg::SCORE_W'(bias_s2) : acc_q;
		acc_next = acc_base + sscp_pkg::SCORE_W'(ph_s2) + sscp_pkg::SCORE_W'(ps_s2);
		// strict compare keeps the lowest id on ties
		take     = (tag_s2.v == '0) || (acc_next > lead_score_q);
	end

	always_ff @(posedge clk) begin
		if (tag_s2.valid) begin
			acc_q <= acc_next;
			if (tag_s2.last && take) begin
				lead_score_q <= acc_next;
				best_id_q    <= tag_s2.v;
			end
		end
	end

	always_comb begin
		res.fire  = tag_s2.valid && tag_s2.fin;
		res.id    = take ? tag_s2.v : best_id_q;
		res.score = take ? acc_next : lead_score_q;
	end

endmodule

`default_nettype wire

### hdl/saturating_sum_char_predictor.sv
// saturating_sum_char_predictor: top level with tables, running sum and step sequencer
// depends on sscp_pkg and sscp_mac
//
// channel   signals                                            direction
// command   start, busy, mode, row, column, weight,            in (busy out)
//           emb_value, char_id
// result    done, prediction_valid, predicted_id, top_score    out
// config    cfg_we, cfg_wdata (vocab_in_use)                   in
//
// load, clear and unused modes never raise busy; done rises in the cycle after acceptance.
// a step reads one embedding per cycle to update the running sum, then passes one
// head-table beat per cycle for each clamped vocab_in_use row through the single
// multiply pair and drains the read and accumulate stages. busy is high meanwhile.
// reset clears the running sum and the sequencer; the tables hold garbage until loaded.
// done is a one-cycle strobe; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

module saturating_sum_char_predictor (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [sscp_pkg::MODE_W-1:0]            mode,
	input  logic [sscp_pkg::VOCAB_W-1:0]           row,
	input  logic [sscp_pkg::DIM_W-1:0]             column,
	input  logic signed [sscp_pkg::WEIGHT_W-1:0]   weight,
	input  logic signed [sscp_pkg::EMB_W-1:0]      emb_value,
	input  logic [sscp_pkg::VOCAB_W-1:0]           char_id,
	output logic                                   done,
	output logic                                   prediction_valid,
	output logic [sscp_pkg::VOCAB_W-1:0]           predicted_id,
	output logic signed [sscp_pkg::SCORE_W-1:0]    top_score,
	input  logic                                   cfg_we,
	input  logic [sscp_pkg::CFG_W-1:0]             cfg_wdata
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_ABSORB = 4'b0010,
		ST_SCORE  = 4'b0100,
		ST_DRAIN  = 4'b1000
	} state_t;

	localparam logic [sscp_pkg::DIM_W-1:0] D_LAST = sscp_pkg::DIM_W'(sscp_pkg::DIM - 1);
	localparam logic [sscp_pkg::CFG_W-1:0] N_MAX  = sscp_pkg::CFG_W'(sscp_pkg::VOCAB_MAX);

	state_t                              state_q;
	logic [sscp_pkg::CFG_W-1:0]          vocab_q;
	logic [sscp_pkg::VOCAB_W-1:0]        cid_q;
	logic [sscp_pkg::VOCAB_W-1:0]        v_q;
	logic [sscp_pkg::VOCAB_W-1:0]        nlast_q;
	logic [sscp_pkg::DIM_W-1:0]          d_q;
	logic [sscp_pkg::DIM_W-1:0]          d_s1;
	logic                                absorb_s1;
	sscp_pkg::tag_t                      tag_iss;
	sscp_pkg::tag_t                      tag_s1;
	sscp_pkg::result_t                   res;
	sscp_pkg::mode_t                     mode_in;

	logic                                accept;
	logic [sscp_pkg::CFG_W-1:0]          n_eff;
	logic [sscp_pkg::CFG_W-1:0]          n_last_w;
	logic [sscp_pkg::ADDR_W-1:0]         wr_addr;
	logic                                we_emb, we_h, we_s, we_b, do_clear, do_step;

	logic signed [sscp_pkg::EMB_W-1:0]    emb_mem    [sscp_pkg::TABLE_DEPTH];
	logic signed [sscp_pkg::WEIGHT_W-1:0] head_h_mem [sscp_pkg::TABLE_DEPTH];
	logic signed [sscp_pkg::WEIGHT_W-1:0] head_s_mem [sscp_pkg::TABLE_DEPTH];
	logic signed [sscp_pkg::WEIGHT_W-1:0] bias_mem   [sscp_pkg::VOCAB_MAX];

	logic signed [sscp_pkg::EMB_W-1:0]    emb_rd_s1;
	logic signed [sscp_pkg::WEIGHT_W-1:0] head_h_s1;
	logic signed [sscp_pkg::WEIGHT_W-1:0] head_s_s1;
	logic signed [sscp_pkg::WEIGHT_W-1:0] bias_s1;

	logic signed [sscp_pkg::EMB_W-1:0]    sum_q [sscp_pkg::DIM];
	logic signed [sscp_pkg::EMB_W-1:0]    emb_q [sscp_pkg::DIM];

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign mode_in = sscp_pkg::mode_t'(mode);
	assign wr_addr = {row, column};

	always_comb begin
		we_emb   = 1'b0;
		we_h     = 1'b0;
		we_s     = 1'b0;
		we_b     = 1'b0;
		do_clear = 1'b0;
		do_step  = 1'b0;
		unique case (mode_in)
			sscp_pkg::MODE_LOAD_EMB: we_emb   = accept;
			sscp_pkg::MODE_LOAD_H:   we_h     = accept;
			sscp_pkg::MODE_LOAD_S:   we_s     = accept;
			sscp_pkg::MODE_LOAD_B:   we_b     = accept;
			sscp_pkg::MODE_CLEAR:    do_clear = accept;
			sscp_pkg::MODE_STEP:     do_step  = accept;
			default: ;
		endcase
	end

	// clamp vocab_in_use into 1..VOCAB_MAX
	always_comb begin
		n_eff = vocab_q;
		if (vocab_q == '0) n_eff = sscp_pkg::CFG_W'(1);
		if (vocab_q > N_MAX) n_eff = N_MAX;
		n_last_w = n_eff - sscp_pkg::CFG_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vocab_q <= sscp_pkg::VOCAB_RESET;
		end else if (cfg_we) begin
			vocab_q <= cfg_wdata;
		end
	end

	// tables: one write port at load, one registered read port each
	always_ff @(posedge clk) begin
		if (we_emb) emb_mem[wr_addr] <= sscp_pkg::clamp_emb({emb_value[sscp_pkg::EMB_W-1], emb_value});
		if (we_h)   head_h_mem[wr_addr] <= weight;
		if (we_s)   head_s_mem[wr_addr] <= weight;
		if (we_b)   bias_mem[row] <= weight;
		emb_rd_s1 <= emb_mem[{cid_q, d_q}];
		head_h_s1 <= head_h_mem[{v_q, d_q}];
		head_s_s1 <= head_s_mem[{v_q, d_q}];
		bias_s1   <= bias_mem[v_q];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			d_q     <= '0;
			v_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					d_q <= '0;
					v_q <= '0;
					if (do_step) state_q <= ST_ABSORB;
				end
				ST_ABSORB: begin
					d_q <= d_q + 1'b1;
					if (d_q == D_LAST) begin
						d_q     <= '0;
						state_q <= ST_SCORE;
					end
				end
				ST_SCORE: begin
					d_q <= d_q + 1'b1;
					if (d_q == D_LAST) begin
						d_q <= '0;
						v_q <= v_q + 1'b1;
						if (v_q == nlast_q) state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (res.fire) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			cid_q   <= char_id;
			nlast_q <= n_last_w[sscp_pkg::VOCAB_W-1:0];
		end
		d_s1 <= d_q;
	end

	always_comb begin
		tag_iss.valid = (state_q == ST_SCORE);
		tag_iss.first = (d_q == '0);
		tag_iss.last  = (d_q == D_LAST);
		tag_iss.fin   = (d_q == D_LAST) && (v_q == nlast_q);
		tag_iss.v     = v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			absorb_s1 <= 1'b0;
			tag_s1    <= '0;
		end else begin
			absorb_s1 <= (state_q == ST_ABSORB);
			tag_s1    <= tag_iss;
		end
	end

	// running sum: cleared on reset or clear, absorbs the character one element per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sscp_pkg::DIM; i++) sum_q[i] <= '0;
		end else if (do_clear) begin
			for (int i = 0; i < sscp_pkg::DIM; i++) sum_q[i] <= '0;
		end else if (absorb_s1) begin
			sum_q[d_s1] <= sscp_pkg::clamp_emb(
				{sum_q[d_s1][sscp_pkg::EMB_W-1], sum_q[d_s1]} +
				{emb_rd_s1[sscp_pkg::EMB_W-1], emb_rd_s1});
		end
	end

	always_ff @(posedge clk) begin
		if (absorb_s1) emb_q[d_s1] <= emb_rd_s1;
	end

	sscp_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s1    (tag_s1),
		.head_h_s1 (head_h_s1),
		.head_s_s1 (head_s_s1),
		.bias_s1   (bias_s1),
		.emb_s1    (emb_q[d_s1]),
		.sum_s1    (sum_q[d_s1]),
		.res       (res)
	);

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= (accept && !do_step) || res.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (res.fire) begin
			prediction_valid <= 1'b1;
			predicted_id     <= res.id;
			top_score        <= res.score;
		end else if (accept) begin
			prediction_valid <= 1'b0;
			predicted_id     <= '0;
			top_score        <= '0;
		end
	end

endmodule

`default_nettype wire

### hdl/sscp_checker.sv
// sscp_checker: port-level checks on the predictor's command and result words
// depends on sscp_pkg; bound to saturating_sum_char_predictor below
`timescale 1ns / 1ps
`default_nettype none

module sscp_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  start,
	input logic                                  busy,
	input logic [sscp_pkg::MODE_W-1:0]           mode,
	input logic                                  done,
	input logic                                  prediction_valid,
	input logic [sscp_pkg::VOCAB_W-1:0]          predicted_id,
	input logic signed [sscp_pkg::SCORE_W-1:0]   top_score
);

	logic is_step;
	assign is_step = (mode == sscp_pkg::MODE_STEP);

	// non-step word answers on the next cycle with a blank result
	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !is_step |=> done && !prediction_valid)
		else $error("non-step word did not answer next cycle");

	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && is_step |=> busy && !done)
		else $error("step word did not raise busy");

	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		done && !prediction_valid |-> predicted_id == '0 && top_score == '0)
		else $error("blank result carries data");

	// a step ends exactly when its prediction appears
	a_step_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done && prediction_valid)
		else $error("busy fell without a prediction");

	a_pred_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && prediction_valid |-> $past(busy))
		else $error("prediction without a running step");

endmodule

bind saturating_sum_char_predictor sscp_checker u_sscp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.mode             (mode),
	.done             (done),
	.prediction_valid (prediction_valid),
	.predicted_id     (predicted_id),
	.top_score        (top_score)
);

`default_nettype wire
